/* rtl/core/mlsc_pkg.sv */
// shared types and codes for the multi-list store
package mlsc_pkg;

  localparam int MAX_LISTS  = 16;
  localparam int MAX_SONGS  = 256;
  localparam int VALUE_BITS = 16;

  localparam logic [2:0] MODE_CREATE  = 3'd0;
  localparam logic [2:0] MODE_DELETE  = 3'd1;
  localparam logic [2:0] MODE_APPEND  = 3'd2;
  localparam logic [2:0] MODE_REMOVE  = 3'd3;
  localparam logic [2:0] MODE_REBUILD = 3'd4;
  localparam logic [2:0] MODE_READ    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_IDX  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  list_index;
    logic [15:0] song_value;
    logic [7:0]  position;
    logic [15:0] library_count;
  } mlsc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  new_list_index;
    logic [4:0]  lists_in_use;
    logic [8:0]  list_length;
    logic [15:0] entry_value;
  } mlsc_out_t;

endpackage

/* rtl/core/multi_list_store_compacting_unit.sv */
// multi-list store: sequencer, length table and entry memory
//
// channel | dir | ports
// in      | in  | in_valid, in_ready, in_data (mlsc_in_t)
// out     | out | out_valid, out_ready, out_data (mlsc_out_t)
//
// one item at a time; in_ready is high only when the sequencer is idle
// and the result register is free or being taken
// remove and delete move one entry at a time through the read request, read wait
// and compare/write states; read stops after the read wait; rebuild fills list 0
// with the values 0 upward; create, append and unknown modes go straight to done
// rst_n (sync) clears list count to one and all lengths; memory is not cleared
// a stalled result holds the result register and blocks new items
module multi_list_store_compacting_unit
  import mlsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mlsc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mlsc_out_t out_data
);

  localparam int LB = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int SB = (MAX_SONGS > 1) ? $clog2(MAX_SONGS) : 1;
  localparam int CB = $clog2(MAX_LISTS + 1);  // list count width
  localparam int NB = $clog2(MAX_SONGS + 1);  // length width
  localparam int AB = LB + SB;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDREQ = 3'd1;  // issue memory read
  localparam logic [2:0] S_RDWT  = 3'd2;  // read data registered
  localparam logic [2:0] S_SRCH  = 3'd3;  // compare / move
  localparam logic [2:0] S_FILL  = 3'd4;  // rebuild writes
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  mlsc_in_t   cmd_r;
  logic [CB-1:0] total_r;
  logic [NB-1:0] len_r [MAX_LISTS];

  // entry memory, one read and one write address per cycle
  logic [VALUE_BITS-1:0] mem [MAX_LISTS * MAX_SONGS];
  logic [VALUE_BITS-1:0] rdata_r;
  logic          we;
  logic [AB-1:0] waddr, raddr;
  logic [VALUE_BITS-1:0] wdata;

  // walk state
  logic [LB-1:0] lst_r;   // current list in walk
  logic [NB-1:0] pos_r;   // current entry
  logic          found_r; // remove: match seen, now compacting
  logic [1:0]    stat_r;

  logic          ovld_r;
  mlsc_out_t     odata_r;

  logic [VALUE_BITS-1:0] val;
  assign val = cmd_r.song_value[VALUE_BITS-1:0];

  function automatic logic [AB-1:0] addr_of(logic [LB-1:0] l, logic [NB-1:0] p);
    logic [SB-1:0] ps;
    ps = p[SB-1:0];
    return {l, ps};
  endfunction

  logic [LB-1:0] li;
  assign li = cmd_r.list_index[LB-1:0];
  logic idx_ok;
  assign idx_ok = ({1'b0, cmd_r.list_index} < total_r)
                  && (32'(cmd_r.list_index) < MAX_LISTS);
  // slot of the last list, cleared when a list is deleted
  logic [CB-1:0] last_c;
  assign last_c = total_r - CB'(1);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign in_ready = (state_r == S_IDLE) && (!ovld_r || out_ready);

  always_comb begin
    we    = 1'b0;
    waddr = addr_of(lst_r, pos_r);
    wdata = rdata_r;
    raddr = addr_of(lst_r, pos_r);
    case (state_r)
      S_FILL: begin
        we    = 1'b1;
        wdata = VALUE_BITS'(pos_r);
        waddr = addr_of('0, pos_r);
      end
      S_SRCH: begin
        // remove compaction: write entry pos-1 with read data
        if (cmd_r.mode == MODE_REMOVE && found_r) begin
          we    = 1'b1;
          waddr = addr_of(lst_r, pos_r - NB'(1));
        end else if (cmd_r.mode == MODE_DELETE) begin
          // delete shift: write list-1 at pos
          we    = 1'b1;
          waddr = addr_of(lst_r - LB'(1), pos_r);
        end
      end
      S_DONE: begin
        // append: store the value behind the last entry
        if (cmd_r.mode == MODE_APPEND && idx_ok && 32'(len_r[li]) < MAX_SONGS) begin
          we    = 1'b1;
          wdata = val;
          waddr = addr_of(li, len_r[li]);
        end
      end
      default: ;
    endcase
  end

  // sequencer and table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= CB'(1);
      for (int k = 0; k < MAX_LISTS; k++) len_r[k] <= '0;
      ovld_r  <= 1'b0;
    end else begin
      if (state_r == S_DONE) ovld_r <= 1'b1;
      else if (ovld_r && out_ready) ovld_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          cmd_r   <= in_data;
          found_r <= 1'b0;
          stat_r  <= ST_OK;
          // read needs memory at the requested position
          if (in_data.mode == MODE_READ) pos_r <= NB'(in_data.position);
          else pos_r <= '0;
          if (in_data.mode == MODE_DELETE)
            lst_r <= in_data.list_index[LB-1:0] + LB'(1);
          else lst_r <= in_data.list_index[LB-1:0];
          case (in_data.mode)
            MODE_DELETE, MODE_REMOVE, MODE_READ: state_r <= S_RDREQ;
            MODE_REBUILD: state_r <= S_FILL;
            default: state_r <= S_DONE;
          endcase
        end
        S_RDREQ: begin
          // early termination checks
          if (cmd_r.mode == MODE_REMOVE &&
              (!idx_ok || pos_r >= len_r[li])) begin
            if (!found_r) stat_r <= idx_ok ? ST_NOT_FOUND : ST_BAD_IDX;
            else len_r[li] <= len_r[li] - NB'(1);
            state_r <= S_DONE;
          end else if (cmd_r.mode == MODE_DELETE &&
                       (cmd_r.list_index == 4'd0 || !idx_ok ||
                        CB'(lst_r) >= total_r || lst_r == '0)) begin
            if (cmd_r.list_index == 4'd0 || !idx_ok) stat_r <= ST_BAD_IDX;
            else begin
              for (int k = 0; k < MAX_LISTS - 1; k++)
                if (k >= int'(li) && k + 1 < int'(total_r)) len_r[k] <= len_r[k+1];
              len_r[last_c[LB-1:0]] <= '0;
              total_r <= total_r - CB'(1);
            end
            state_r <= S_DONE;
          end else state_r <= S_RDWT;
        end
        S_RDWT: begin
          if (cmd_r.mode == MODE_READ) state_r <= S_DONE;
          else state_r <= S_SRCH;
        end
        S_SRCH: begin
          state_r <= S_RDREQ;
          if (cmd_r.mode == MODE_REMOVE && !found_r && rdata_r == val)
            found_r <= 1'b1;
          if (cmd_r.mode == MODE_DELETE && pos_r == NB'(MAX_SONGS - 1)) begin
            pos_r <= '0;
            lst_r <= lst_r + LB'(1);
          end else pos_r <= pos_r + NB'(1);
        end
        S_FILL: begin
          if (cmd_r.library_count == 16'd0 || pos_r + NB'(1) >= NB'(MAX_SONGS) ||
              32'(pos_r) + 1 >= 32'(cmd_r.library_count)) state_r <= S_DONE;
          pos_r <= pos_r + NB'(1);
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      // finish: table updates for create, append and rebuild, and the result
      if (state_r == S_DONE) begin : finish_b
        logic [1:0]    st;
        logic [3:0]    nidx;
        logic [CB-1:0] tot;
        logic [NB-1:0] ln;
        logic [15:0]   ev;
        st = stat_r; nidx = '0; tot = total_r; ln = '0; ev = '0;
        case (cmd_r.mode)
          MODE_CREATE: begin
            if (32'(total_r) >= MAX_LISTS) st = ST_FULL;
            else begin
              nidx = 4'(total_r);
              len_r[total_r[LB-1:0]] <= '0;
              tot = total_r + CB'(1);
            end
          end
          MODE_APPEND: begin
            if (!idx_ok) st = ST_BAD_IDX;
            else if (32'(len_r[li]) >= MAX_SONGS) st = ST_FULL;
            else begin
              len_r[li] <= len_r[li] + NB'(1);
              ln = len_r[li] + NB'(1);
            end
          end
          MODE_REBUILD: begin
            ln = (32'(cmd_r.library_count) > MAX_SONGS) ? NB'(MAX_SONGS)
                 : NB'(cmd_r.library_count);
            len_r[0] <= ln;
          end
          MODE_READ: begin
            if (!idx_ok) st = ST_BAD_IDX;
            else if (32'(cmd_r.position) < 32'(len_r[li]) &&
                     32'(cmd_r.position) < MAX_SONGS)
              ev = 16'(rdata_r);
          end
          MODE_DELETE, MODE_REMOVE: ;
          default: st = ST_BAD_IDX;
        endcase
        if (cmd_r.mode != MODE_APPEND && cmd_r.mode != MODE_REBUILD) begin
          if (cmd_r.mode == MODE_CREATE)
            ln = '0;
          else if ({1'b0, cmd_r.list_index} < 5'(tot) &&
                   32'(cmd_r.list_index) < MAX_LISTS)
            ln = len_r[li];
        end else if (cmd_r.mode == MODE_APPEND && st != ST_OK && idx_ok)
          ln = len_r[li];
        total_r <= tot;
        odata_r.status         <= st;
        odata_r.new_list_index <= nidx;
        odata_r.lists_in_use   <= 5'(tot);
        odata_r.list_length    <= 9'(ln);
        odata_r.entry_value    <= ev;
      end
    end
  end

  assign out_valid = ovld_r;
  assign out_data  = odata_r;

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != '0) && (32'(total_r) <= MAX_LISTS))
    else $error("list count out of range");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");

endmodule

/* sim/tb_multi_list_store_compacting_unit.sv */
// testbench for the multi-list store: scoreboard class and driving tasks
`timescale 1ns / 100ps

module tb_multi_list_store_compacting_unit;
  import mlsc_pkg::*;

  localparam int NUM_LISTS  = 16;
  localparam int LIST_DEPTH = 256;
  localparam int ITEM_GOAL  = 1850;
  localparam int QUIET_TAIL = 200;   // last items run with no idling
  localparam logic [2:0] MODE_UNKNOWN_A = 3'd6;
  localparam logic [2:0] MODE_UNKNOWN_B = 3'd7;

  // shadow copy of the list store, predicts every result in order
  class list_store_board;
    bit [4:0]  total;
    int        len [NUM_LISTS];
    bit [15:0] ent [NUM_LISTS][LIST_DEPTH];
    mlsc_out_t pending [$];
    int        mismatches;
    int        checked;

    function new();
      total = 1;
      foreach (len[i]) len[i] = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    // work out the result of one accepted item and update the shadow state
    function void note_item(mlsc_in_t d);
      mlsc_out_t o;
      int li;
      int rep;
      int n;
      bit ok;
      bit hit;
      o = '0;
      li = d.list_index;
      ok = li < total;
      rep = li;
      case (d.mode)
        MODE_CREATE: begin
          if (total >= NUM_LISTS) begin
            o.status = ST_FULL;
            rep = NUM_LISTS;   // nothing addressed
          end else begin
            o.new_list_index = total[3:0];
            len[total] = 0;
            rep = total;
            total++;
          end
        end
        MODE_DELETE: begin
          if (li == 0 || !ok) o.status = ST_BAD_IDX;
          else begin
            // later lists slide down one slot
            for (int i = li; i + 1 < total; i++) begin
              len[i] = len[i+1];
              ent[i] = ent[i+1];
            end
            len[total-1] = 0;
            total--;
          end
        end
        MODE_APPEND: begin
          if (!ok) o.status = ST_BAD_IDX;
          else if (len[li] >= LIST_DEPTH) o.status = ST_FULL;
          else begin
            ent[li][len[li]] = d.song_value;
            len[li]++;
          end
        end
        MODE_REMOVE: begin
          if (!ok) o.status = ST_BAD_IDX;
          else begin
            hit = 0;
            n = len[li];
            for (int i = 0; i < n; i++) begin
              if (!hit && ent[li][i] == d.song_value) hit = 1;
              if (hit && i + 1 < n) ent[li][i] = ent[li][i+1];
            end
            if (hit) len[li] = n - 1;
            else o.status = ST_NOT_FOUND;
          end
        end
        MODE_REBUILD: begin
          n = (d.library_count > LIST_DEPTH) ? LIST_DEPTH : d.library_count;
          for (int i = 0; i < n; i++) ent[0][i] = i[15:0];
          len[0] = n;
          rep = 0;
        end
        MODE_READ: begin
          if (!ok) o.status = ST_BAD_IDX;
          else if (d.position < len[li]) o.entry_value = ent[li][d.position];
        end
        default: o.status = ST_BAD_IDX;
      endcase
      o.lists_in_use = total;
      o.list_length = (rep < total) ? len[rep][8:0] : 9'd0;
      pending.push_back(o);
    endfunction

    // compare one delivered result with the oldest prediction
    function void check_result(mlsc_out_t got);
      mlsc_out_t exp_o;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_o = pending.pop_front();
      if (got.status !== exp_o.status || got.new_list_index !== exp_o.new_list_index ||
          got.lists_in_use !== exp_o.lists_in_use ||
          got.list_length !== exp_o.list_length || got.entry_value !== exp_o.entry_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: expected %p got %p", checked, exp_o, got);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  mlsc_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  mlsc_out_t out_data;

  list_store_board board;
  int  items_sent;
  int  mode_count [8];
  bit  quiet;        // no idling in the last stretch
  bit  hold_req;     // asks the receiver for one long hold-off
  int  hold_cycles;

  multi_list_store_compacting_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // offer one item and wait for its acceptance, with an optional idle burst first
  task automatic send_item(mlsc_in_t d);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk);
    end
    in_data = d;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_item(d);
    mode_count[d.mode]++;
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic mlsc_in_t make_item(logic [2:0] m, int li, int v, int p, int lib);
    mlsc_in_t d;
    d.mode = m;
    d.list_index = li[3:0];
    d.song_value = v[15:0];
    d.position = p[7:0];
    d.library_count = lib[15:0];
    return d;
  endfunction

  // random item, mostly well formed against the current shadow state
  function automatic mlsc_in_t pick_item();
    mlsc_in_t d;
    int r;
    int li;
    int n;
    d.song_value = 16'($urandom());
    d.position = 8'($urandom());
    d.library_count = 16'($urandom());
    // list index mostly in range
    if ($urandom_range(0, 99) < 85) li = $urandom_range(0, board.total - 1);
    else li = $urandom_range(0, NUM_LISTS - 1);
    d.list_index = li[3:0];
    n = (li < board.total) ? board.len[li] : 0;
    r = $urandom_range(0, 99);
    if (r < 12) d.mode = MODE_CREATE;
    else if (r < 16) d.mode = MODE_DELETE;
    else if (r < 50) d.mode = MODE_APPEND;
    else if (r < 70) d.mode = MODE_REMOVE;
    else if (r < 74) d.mode = MODE_REBUILD;
    else if (r < 97) d.mode = MODE_READ;
    else d.mode = ($urandom_range(0, 1) == 0) ? MODE_UNKNOWN_A : MODE_UNKNOWN_B;
    // small value range so removes find matches, sometimes a stored value
    r = $urandom_range(0, 9);
    if (r < 5) d.song_value = 16'($urandom_range(0, 15));
    else if (r < 8 && n > 0) d.song_value = board.ent[li][$urandom_range(0, n - 1)];
    if (n > 0 && $urandom_range(0, 3) != 0) d.position = 8'($urandom_range(0, n - 1));
    r = $urandom_range(0, 9);
    if (r < 7) d.library_count = 16'($urandom_range(0, 40));
    else if (r == 7) d.library_count = 16'(LIST_DEPTH);
    return d;
  endfunction

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    stall = 0;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        hold_cycles++;
        if (hold_cycles >= 400) hold_req = 1'b0;
      end else if (quiet) begin
        out_ready = 1'b1;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall = $urandom_range(1, 14) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) board.check_result(out_data);

  initial begin : watchdog
    #40000000;
    $display("multi_list_store_compacting_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int wait_cycles;
    board = new();
    in_valid = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    foreach (mode_count[i]) mode_count[i] = 0;
    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes and every status
    send_item(make_item(MODE_READ, 0, 0, 0, 0));           // empty list
    send_item(make_item(MODE_REBUILD, 0, 0, 0, 300));      // saturating rebuild
    send_item(make_item(MODE_APPEND, 0, 'hffff, 0, 0));    // list full
    send_item(make_item(MODE_READ, 0, 0, 255, 0));
    send_item(make_item(MODE_READ, 0, 0, 0, 0));
    send_item(make_item(MODE_REMOVE, 0, 5, 0, 0));         // compaction
    send_item(make_item(MODE_READ, 0, 0, 5, 0));
    send_item(make_item(MODE_REMOVE, 0, 999, 0, 0));       // value missing
    send_item(make_item(MODE_DELETE, 0, 0, 0, 0));         // protected list
    send_item(make_item(MODE_DELETE, 9, 0, 0, 0));         // bad index
    send_item(make_item(MODE_APPEND, 15, 1, 0, 0));
    send_item(make_item(MODE_READ, 15, 0, 0, 0));
    send_item(make_item(MODE_REMOVE, 3, 0, 0, 0));
    send_item(make_item(MODE_UNKNOWN_A, 0, 0, 0, 0));      // unknown modes
    send_item(make_item(MODE_UNKNOWN_B, 15, 'hffff, 255, 'hffff));
    send_item(make_item(MODE_REBUILD, 0, 0, 0, 'hffff));
    send_item(make_item(MODE_CREATE, 0, 0, 0, 0));
    send_item(make_item(MODE_CREATE, 0, 0, 0, 0));
    send_item(make_item(MODE_APPEND, 1, 'hffff, 0, 0));
    send_item(make_item(MODE_APPEND, 1, 0, 0, 0));
    send_item(make_item(MODE_REMOVE, 1, 'hffff, 0, 0));
    send_item(make_item(MODE_READ, 1, 0, 0, 0));
    send_item(make_item(MODE_DELETE, 1, 0, 0, 0));
    send_item(make_item(MODE_REBUILD, 0, 0, 0, 0));        // empty rebuild

    // random part
    while (items_sent < ITEM_GOAL) begin
      if (items_sent == 400) hold_req = 1'b1;
      if (items_sent == 900) begin
        // sender pause until everything has drained
        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000) begin
          @(negedge clk);
          wait_cycles++;
        end
      end
      if (items_sent >= ITEM_GOAL - QUIET_TAIL) quiet = 1'b1;
      send_item(pick_item());
    end

    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (600) @(negedge clk);

    $display("sent %0d items: create %0d delete %0d append %0d remove %0d rebuild %0d read %0d",
             items_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
             mode_count[4], mode_count[5]);
    $display("checked %0d results, %0d mismatches, %0d left waiting",
             board.checked, board.mismatches, board.pending.size());
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("multi_list_store_compacting_unit verification clean");
    end else begin
      $display("multi_list_store_compacting_unit verification failed");
    end
    $finish;
  end

endmodule

/* multi_list_store_compacting_unit.f */
rtl/core/mlsc_pkg.sv
rtl/core/multi_list_store_compacting_unit.sv
sim/tb_multi_list_store_compacting_unit.sv
